// File: rtl/rmt_pkg.sv
package rmt_pkg;

   localparam int FREQ_W            = 25;
   localparam int MENU_W            = 3;
   localparam int OPT_W             = 3;
   localparam int MENU_SLOTS        = 8;
   localparam int NUM_DIGITS        = 6;
   localparam int NUM_MENUS_DEFAULT = 6;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int REQ_TDATA_W       = 8;
   localparam int REQ_TUSER_W       = 3;
   localparam int RSP_TDATA_W       = 48;

   localparam logic [FREQ_W-1:0] MAX_FREQ_RESET = FREQ_W'(30000000);
   localparam logic [FREQ_W-1:0] MIN_FREQ_RESET = FREQ_W'(100);
   localparam logic [FREQ_W-1:0] FREQ_RESET     = FREQ_W'(7074000);
   localparam logic [OPT_W-1:0]  OPTION_RESET   = OPT_W'(4);

   localparam logic [MENU_W-1:0] MENU_TUNE  = MENU_W'(0);
   localparam logic [MENU_W-1:0] MENU_FIRST = MENU_W'(1);

   // Register index, taken from bit 2 of the byte address.
   localparam logic REG_MAX_FREQ = 1'b0;
   localparam logic REG_MIN_FREQ = 1'b1;

   typedef enum logic [2:0] {
      SRC_ENCODER = 3'd0,
      SRC_ENTER   = 3'd1,
      SRC_ESCAPE  = 3'd2,
      SRC_LEFT    = 3'd3,
      SRC_RIGHT   = 3'd4
   } src_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic       falling_edge;
      logic       encoder_b_level;
   } event_type;

   typedef struct packed {
      logic [FREQ_W-1:0] max_frequency;
      logic [FREQ_W-1:0] min_frequency;
   } cfg_type;

   typedef struct packed {
      logic [2:0]        band_choice;
      logic [1:0]        vox_choice;
      logic [2:0]        preamp_choice;
      logic [1:0]        agc_choice;
      logic [1:0]        mode_choice;
      logic              commit_pulse;
      logic [FREQ_W-1:0] tuned_frequency;
      logic [OPT_W-1:0]  current_option;
      logic [MENU_W-1:0] menu_state;
   } result_type;

   // Step size of each tuning digit; an index past the last digit uses 100 Hz.
   function automatic logic [FREQ_W-1:0] digit_step(input logic [OPT_W-1:0] digit);
      logic [FREQ_W-1:0] step;
      case (digit)
         3'd0:    step = FREQ_W'(10000000);
         3'd1:    step = FREQ_W'(1000000);
         3'd2:    step = FREQ_W'(100000);
         3'd3:    step = FREQ_W'(10000);
         3'd4:    step = FREQ_W'(1000);
         default: step = FREQ_W'(100);
      endcase
      return step;
   endfunction

   // Highest option index of each menu.
   function automatic logic [OPT_W-1:0] option_top(input logic [MENU_W-1:0] menu);
      logic [OPT_W-1:0] top;
      case (menu)
         3'd0:    top = OPT_W'(5);
         3'd1:    top = OPT_W'(3);
         3'd2:    top = OPT_W'(2);
         3'd3:    top = OPT_W'(4);
         3'd4:    top = OPT_W'(3);
         3'd5:    top = OPT_W'(4);
         default: top = OPT_W'(7);
      endcase
      return top;
   endfunction

   function automatic logic [OPT_W-1:0] saved_reset(input logic [MENU_W-1:0] menu);
      logic [OPT_W-1:0] val;
      case (menu)
         3'd0:    val = OPT_W'(4);
         3'd3:    val = OPT_W'(3);
         3'd5:    val = OPT_W'(2);
         default: val = OPT_W'(0);
      endcase
      return val;
   endfunction

endpackage

// File: rtl/rmt_csr.sv
module rmt_csr
   import rmt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [FREQ_W-1:0] max_freq_ff, max_freq_in;
   logic [FREQ_W-1:0] min_freq_ff, min_freq_in;
   logic              wr_en;
   logic              reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      max_freq_in = max_freq_ff;
      min_freq_in = min_freq_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_MAX_FREQ: max_freq_in = csr_pwdata[FREQ_W-1:0];
            REG_MIN_FREQ: min_freq_in = csr_pwdata[FREQ_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_freq_ff <= MAX_FREQ_RESET;
         min_freq_ff <= MIN_FREQ_RESET;
      end else begin
         max_freq_ff <= max_freq_in;
         min_freq_ff <= min_freq_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MAX_FREQ: csr_prdata = CSR_DATA_W'(max_freq_ff);
         REG_MIN_FREQ: csr_prdata = CSR_DATA_W'(min_freq_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg.max_frequency = max_freq_ff;
   assign cfg.min_frequency = min_freq_ff;

endmodule

// File: rtl/rmt_in_reg.sv
module rmt_in_reg
   import rmt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  event_type in_event,
   output logic      ev_valid,
   input  logic      ev_ready,
   output event_type ev_event
);

   logic      valid_ff, valid_in;
   event_type event_ff, event_in;
   logic      take;

   // The stage refills in the same cycle that the engine drains it.
   assign in_ready = !valid_ff || ev_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      event_in = event_ff;
      if (take) begin
         valid_in = 1'b1;
         event_in = in_event;
      end else if (ev_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      event_ff <= event_in;
   end

   assign ev_valid = valid_ff;
   assign ev_event = event_ff;

endmodule

// File: rtl/rmt_engine.sv
module rmt_engine
   import rmt_pkg::*;
#(
   parameter int NUM_MENUS = NUM_MENUS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       ev_valid,
   output logic       ev_ready,
   input  event_type  ev_event,
   output logic       res_valid,
   input  logic       res_ready,
   output result_type res_data
);

   localparam logic [MENU_W-1:0] MENU_LAST  = MENU_W'(NUM_MENUS - 1);
   localparam logic [OPT_W-1:0]  DIGIT_LAST = OPT_W'(NUM_DIGITS - 1);

   logic [MENU_W-1:0] menu_ff, menu_in;
   logic [OPT_W-1:0]  option_ff, option_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic [OPT_W-1:0]  saved_ff [MENU_SLOTS];
   logic [OPT_W-1:0]  saved_in [MENU_SLOTS];
   logic              commit;
   logic              fire;
   logic              active;
   src_type           src;
   logic [FREQ_W-1:0] step;
   logic [FREQ_W:0]   freq_up;
   logic [FREQ_W:0]   freq_floor;
   logic [OPT_W-1:0]  top;

   logic       res_valid_ff, res_valid_in;
   result_type res_data_ff, res_data_in;

   assign ev_ready = !res_valid_ff || res_ready;
   assign fire     = ev_valid && ev_ready;
   assign src      = src_type'(ev_event.req_type);
   assign active   = fire && ev_event.falling_edge;

   assign step       = digit_step(option_ff);
   assign freq_up    = {1'b0, freq_ff} + {1'b0, step};
   assign freq_floor = {1'b0, cfg.min_frequency} + {1'b0, step};
   assign top        = option_top(menu_ff);

   always_comb begin
      menu_in   = menu_ff;
      option_in = option_ff;
      freq_in   = freq_ff;
      saved_in  = saved_ff;
      commit    = 1'b0;
      if (active) begin
         if (menu_ff == MENU_TUNE) begin
            case (src)
               SRC_ENCODER: begin
                  if (ev_event.encoder_b_level) begin
                     if (freq_up < {1'b0, cfg.max_frequency}) begin
                        freq_in = freq_up[FREQ_W-1:0];
                     end
                  end else if ({1'b0, freq_ff} > freq_floor) begin
                     freq_in = freq_ff - step;
                  end
               end
               SRC_ESCAPE: begin
                  saved_in[MENU_TUNE] = option_ff;
                  menu_in             = MENU_FIRST;
                  option_in           = saved_ff[MENU_FIRST];
               end
               SRC_LEFT: begin
                  option_in = (option_ff > '0) ? option_ff - 1'b1 : '0;
               end
               SRC_RIGHT: begin
                  option_in = (option_ff < DIGIT_LAST) ? option_ff + 1'b1 : DIGIT_LAST;
               end
               default: ;
            endcase
         end else begin
            case (src)
               SRC_ENCODER: begin
                  if (ev_event.encoder_b_level) begin
                     option_in = (option_ff < top) ? option_ff + 1'b1 : top;
                  end else begin
                     option_in = (option_ff > '0) ? option_ff - 1'b1 : '0;
                  end
               end
               SRC_ENTER: begin
                  saved_in[menu_ff] = option_ff;
                  commit            = 1'b1;
               end
               SRC_ESCAPE: begin
                  menu_in   = MENU_TUNE;
                  option_in = saved_ff[MENU_TUNE];
               end
               SRC_LEFT: begin
                  menu_in   = (menu_ff > MENU_FIRST) ? menu_ff - 1'b1 : MENU_LAST;
                  option_in = saved_ff[menu_in];
               end
               SRC_RIGHT: begin
                  menu_in   = (menu_ff < MENU_LAST) ? menu_ff + 1'b1 : MENU_FIRST;
                  option_in = saved_ff[menu_in];
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      res_valid_in = res_valid_ff;
      res_data_in  = res_data_ff;
      if (fire) begin
         res_valid_in                = 1'b1;
         res_data_in.menu_state      = menu_in;
         res_data_in.current_option  = option_in;
         res_data_in.tuned_frequency = freq_in;
         res_data_in.commit_pulse    = commit;
         res_data_in.mode_choice     = saved_in[1][1:0];
         res_data_in.agc_choice      = saved_in[2][1:0];
         res_data_in.preamp_choice   = saved_in[3];
         res_data_in.vox_choice      = saved_in[4][1:0];
         res_data_in.band_choice     = saved_in[5];
      end else if (res_ready) begin
         res_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         menu_ff      <= MENU_TUNE;
         option_ff    <= OPTION_RESET;
         freq_ff      <= FREQ_RESET;
         res_valid_ff <= 1'b0;
         for (int i = 0; i < MENU_SLOTS; i++) begin
            saved_ff[i] <= saved_reset(MENU_W'(i));
         end
      end else begin
         menu_ff      <= menu_in;
         option_ff    <= option_in;
         freq_ff      <= freq_in;
         res_valid_ff <= res_valid_in;
         saved_ff     <= saved_in;
      end
   end

   always_ff @(posedge clock) begin
      res_data_ff <= res_data_in;
   end

   assign res_valid = res_valid_ff;
   assign res_data  = res_data_ff;

`ifndef NO_ASSERTIONS
   // The menu never leaves the range of menus that exist.
   a_menu_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, menu_ff} < (MENU_W + 1)'(NUM_MENUS))
      else $error("menu index out of range");

   // A commit is only reported from a submenu, which Enter does not leave.
   a_commit_submenu: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && res_data_ff.commit_pulse |-> res_data_ff.menu_state != MENU_TUNE)
      else $error("commit reported outside a submenu");

   // The frequency only moves on an accepted event while tuning.
   a_freq_hold: assert property (@(posedge clock) disable iff (reset)
      !(active && menu_ff == MENU_TUNE) |=> $stable(freq_ff))
      else $error("frequency changed without a tuning event");

   // The frequency never rises to the upper bound through an increment.
   a_freq_below_max: assert property (@(posedge clock) disable iff (reset)
      active && menu_ff == MENU_TUNE && freq_in != freq_ff && freq_in > freq_ff
      |-> freq_in < cfg.max_frequency)
      else $error("increment reached the upper bound");
`endif

endmodule

// File: rtl/radio_menu_tuning_fsm.sv
// Front-panel menu and tuning controller for a radio receiver. Each item on the
// req_ channel is one panel event: an encoder step or an edge on the Enter,
// Escape, Left or Right button; items without a falling edge, and stray
// sources, leave the state alone but still produce a result. Every item gives
// exactly one result item on the rsp_ channel showing the menu, the option, the
// tuned frequency, a commit flag and the stored option of each submenu after
// the event. The block accepts one item per clock cycle unless either side
// stalls; each item passes through an input register, then the result register.
// That rate is set by the state update loop, which applies one event per cycle
// from the state left by the previous one. Either side may stall freely: the
// input register refills in the same cycle that the result register drains.
// The user must write the tuning bounds at csr_ byte address 0 (maximum) and
// 4 (minimum) only while no item is in flight; the block does not enforce it.
module radio_menu_tuning_fsm
   import rmt_pkg::*;
#(
   parameter int NUM_MENUS = NUM_MENUS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Event channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // Bit 0 falling_edge, bit 1 encoder_b_level, bits 7:2 zero.
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // Bits 2:0 req_type.
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   // Result channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Bits 2:0 menu_state, 5:3 current_option, 30:6 tuned_frequency,
   // 31 commit_pulse, 33:32 mode_choice, 35:34 agc_choice,
   // 38:36 preamp_choice, 40:39 vox_choice, 43:41 band_choice, 47:44 zero.
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // Configuration port.
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int RES_W = $bits(result_type);

   cfg_type    cfg;
   event_type  in_event;
   event_type  ev_event;
   logic       ev_valid;
   logic       ev_ready;
   result_type res_data;

   // Unpack the incoming item.
   assign in_event.req_type        = req_tuser;
   assign in_event.falling_edge    = req_tdata[0];
   assign in_event.encoder_b_level = req_tdata[1];

   rmt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rmt_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_event (in_event),
      .ev_valid (ev_valid),
      .ev_ready (ev_ready),
      .ev_event (ev_event)
   );

   rmt_engine #(
      .NUM_MENUS (NUM_MENUS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .ev_valid  (ev_valid),
      .ev_ready  (ev_ready),
      .ev_event  (ev_event),
      .res_valid (rsp_tvalid),
      .res_ready (rsp_tready),
      .res_data  (res_data)
   );

   // The result struct is declared with its last field in the lowest bits,
   // so packing is a zero extension to whole bytes.
   assign rsp_tdata = {{(RSP_TDATA_W - RES_W){1'b0}}, res_data};

endmodule
